/* rtl/sdfts_pkg.sv */
`timescale 1ns / 1ps
package sdfts_pkg;

   localparam int RES_MAX_DEF    = 32;
   localparam int DIST_WIDTH_DEF = 16;

   localparam int Q16_HALF = 32768;
   localparam int Q16_ONE  = 65536;

   localparam int OUT_MAX = 32767;
   localparam int OUT_MIN = -32768;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_INV_VOX  = 3'd3,
      CSR_RES_X    = 3'd4,
      CSR_RES_Y    = 3'd5,
      CSR_RES_Z    = 3'd6
   } csr_index_type;

   typedef enum logic {
      KIND_WRITE  = 1'b0,
      KIND_SAMPLE = 1'b1
   } kind_type;

endpackage

/* rtl/sdfts_lerp.sv */
`timescale 1ns / 1ps
module sdfts_lerp import sdfts_pkg::*; #(
   parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic signed [DIST_WIDTH-1:0] a,
   input  logic signed [DIST_WIDTH-1:0] b,
   input  logic        [15:0]           t,
   output logic signed [DIST_WIDTH-1:0] y
);

   localparam int SW = DIST_WIDTH + 19;

   logic signed [SW-1:0]         ax, bx, wa, wb, s;
   logic        [16:0]           wa_u;
   logic signed [DIST_WIDTH-1:0] y_ff, y_in;

   // a*(1-t) + b*t + half, floor by 16: result always lies between a and b
   always_comb begin
      wa_u = 17'(Q16_ONE) - {1'b0, t};
      ax   = SW'(a);
      bx   = SW'(b);
      wa   = $signed(SW'({1'b0, wa_u}));
      wb   = $signed(SW'({1'b0, t}));
      s    = ax * wa + bx * wb + SW'(Q16_HALF);
      y_in = s[16 +: DIST_WIDTH];
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
   end

   assign y = y_ff;

endmodule

/* rtl/sdf_trilinear_sampler.sv */
`timescale 1ns / 1ps
// Trilinear sampler over a signed distance grid. An item is taken in every cycle in which
// start is high (busy is never raised): kind 0 stores one voxel, kind 1 samples the grid at
// a Q16.16 point. Each sample gives one result on the rsp_ ports, marked by rsp_valid for
// exactly one cycle; the receiver cannot stall, so results must be taken as they come.
// Writes give no result. Throughput is one item per clock, set by eight parity banks that
// serve all eight corners in a single read; writes travel down the same pipeline and land
// in the banks at the read stage, so every sample sees exactly the voxels written before
// it. Voxels never written since reset read as garbage.
// Configuration writes must be made only with the pipeline drained.
module sdf_trilinear_sampler import sdfts_pkg::*; #(
   parameter int RES_MAX    = RES_MAX_DEF,
   parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic signed [31:0] req_query_x,
   input  logic signed [31:0] req_query_y,
   input  logic signed [31:0] req_query_z,
   input  logic        [4:0]  req_voxel_i,
   input  logic        [4:0]  req_voxel_j,
   input  logic        [4:0]  req_voxel_k,
   input  logic signed [15:0] req_write_distance,
   // result channel
   output logic               rsp_valid,
   output logic signed [15:0] rsp_sampled_distance,
   output logic               rsp_degenerate,
   // register port
   input  logic               csr_we,
   input  logic        [2:0]  csr_index,
   input  logic        [31:0] csr_wdata
);

   localparam int IW  = $clog2(RES_MAX);          // corner index bits
   localparam int EW  = $clog2(RES_MAX + 1);      // effective resolution bits
   localparam int HR  = (RES_MAX + 1) / 2;        // entries per axis in one bank
   localparam int BD  = HR * HR * HR;             // bank depth
   localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
   localparam int DW  = DIST_WIDTH;

   // ---------------------------------------------------------------- registers
   logic signed [31:0] org_ff [3];
   logic        [31:0] inv_ff;
   logic        [5:0]  res_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            org_ff[a] <= '0;
            res_ff[a] <= '0;
         end
         inv_ff <= 32'(Q16_ONE);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X: org_ff[0] <= $signed(csr_wdata);
            CSR_ORIGIN_Y: org_ff[1] <= $signed(csr_wdata);
            CSR_ORIGIN_Z: org_ff[2] <= $signed(csr_wdata);
            CSR_INV_VOX:  inv_ff    <= csr_wdata;
            CSR_RES_X:    res_ff[0] <= csr_wdata[5:0];
            CSR_RES_Y:    res_ff[1] <= csr_wdata[5:0];
            CSR_RES_Z:    res_ff[2] <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // resolutions above the grid size saturate
   logic [EW-1:0] eff [3];
   logic          degen;
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         eff[a] = (32'(res_ff[a]) > 32'(RES_MAX)) ? EW'(RES_MAX) : EW'(res_ff[a]);
      end
      degen = (eff[0] == '0) || (eff[1] == '0) || (eff[2] == '0) || (inv_ff == '0);
   end

   assign busy = 1'b0;

   // ---------------------------------------------------------------- stage 1: capture
   logic               v1_ff, smp1_ff;
   logic signed [31:0] q1_ff [3];
   logic        [4:0]  wi1_ff [3];
   logic signed [15:0] wd1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start;
      smp1_ff   <= (kind_type'(req_kind) == KIND_SAMPLE);
      q1_ff[0]  <= req_query_x;
      q1_ff[1]  <= req_query_y;
      q1_ff[2]  <= req_query_z;
      wi1_ff[0] <= req_voxel_i;
      wi1_ff[1] <= req_voxel_j;
      wi1_ff[2] <= req_voxel_k;
      wd1_ff    <= req_write_distance;
   end

   // ---------------------------------------------------------------- stage 2: offset
   logic               v2_ff, smp2_ff;
   logic        [31:0] ud2_ff [3];
   logic        [4:0]  wi2_ff [3];
   logic signed [15:0] wd2_ff;
   logic signed [32:0] dq [3];
   logic        [31:0] ud2_in [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dq[a]     = 33'(q1_ff[a]) - 33'(org_ff[a]);
         ud2_in[a] = (dq[a] <= 0) ? '0 : dq[a][31:0];   // left of the origin clamps to 0
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      smp2_ff <= smp1_ff;
      ud2_ff  <= ud2_in;
      wi2_ff  <= wi1_ff;
      wd2_ff  <= wd1_ff;
   end

   // ---------------------------------------------------------------- stage 3: scale
   logic               v3_ff, smp3_ff;
   logic        [63:0] pr3_ff [3];
   logic        [4:0]  wi3_ff [3];
   logic signed [15:0] wd3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      smp3_ff <= smp2_ff;
      for (int a = 0; a < 3; a++) begin
         pr3_ff[a] <= 64'(ud2_ff[a]) * 64'(inv_ff);
      end
      wi3_ff <= wi2_ff;
      wd3_ff <= wd2_ff;
   end

   // ---------------------------------------------------------------- stage 4: clamp, split
   logic               v4_ff, smp4_ff, dg4_ff;
   logic [IW-1:0]      c04_ff [3];
   logic [15:0]        t4_ff [3];
   logic [4:0]         wi4_ff [3];
   logic signed [15:0] wd4_ff;
   logic [47:0]        pq [3];
   logic [47:0]        cv [3];
   logic [47:0]        hi [3];
   logic [EW-1:0]      effm1 [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         pq[a]    = pr3_ff[a][63:16];
         effm1[a] = eff[a] - EW'(1);
         hi[a]    = {32'(effm1[a]), 16'h0};
         cv[a]    = (pq[a] < 48'(Q16_HALF)) ? '0 : pq[a] - 48'(Q16_HALF);
         if (cv[a] > hi[a]) cv[a] = hi[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
      smp4_ff <= smp3_ff;
      dg4_ff  <= degen;
      for (int a = 0; a < 3; a++) begin
         c04_ff[a] <= cv[a][16 +: IW];
         t4_ff[a]  <= cv[a][15:0];
      end
      wi4_ff <= wi3_ff;
      wd4_ff <= wd3_ff;
   end

   // ---------------------------------------------------------------- banked voxel store
   // Bank {z,y,x} parity; each bank holds every second voxel per axis.
   logic [IW-1:0]   c14 [3];
   logic [IW:0]     cinc [3];
   logic [BAW-1:0]  rd_addr [8];
   logic [BAW-1:0]  wr_addr;
   logic [2:0]      wr_bank;
   logic            wr_en;
   logic [DW-1:0]   wr_data;
   logic [IW-1:0]   ci [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         cinc[a] = {1'b0, c04_ff[a]} + (IW+1)'(1);
         c14[a]  = (32'(cinc[a]) < 32'(eff[a])) ? cinc[a][IW-1:0] : IW'(eff[a] - EW'(1));
      end
      for (int b = 0; b < 8; b++) begin
         for (int a = 0; a < 3; a++) begin
            ci[a] = (c04_ff[a][0] == b[a]) ? c04_ff[a] : c14[a];
         end
         rd_addr[b] = BAW'(32'(ci[0] >> 1)
                           + HR * (32'(ci[1] >> 1) + HR * 32'(ci[2] >> 1)));
      end
      wr_bank = {wi4_ff[2][0], wi4_ff[1][0], wi4_ff[0][0]};
      wr_addr = BAW'(32'(wi4_ff[0] >> 1)
                     + HR * (32'(wi4_ff[1] >> 1) + HR * 32'(wi4_ff[2] >> 1)));
      // indices beyond the grid are dropped
      wr_en   = v4_ff && !smp4_ff && (32'(wi4_ff[0]) < RES_MAX)
                && (32'(wi4_ff[1]) < RES_MAX) && (32'(wi4_ff[2]) < RES_MAX);
      wr_data = DW'(wd4_ff);
   end

   logic signed [DW-1:0] rd5_ff [8];

   for (genvar g = 0; g < 8; g++) begin : g_bank
      logic signed [DW-1:0] mem [BD];
      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == 3'(g))) mem[wr_addr] <= wr_data;
         rd5_ff[g] <= mem[rd_addr[g]];
      end
   end

   // ---------------------------------------------------------------- stage 5: corners out
   logic        v5_ff, smp5_ff, dg5_ff;
   logic [15:0] t5_ff [3];
   logic [2:0]  p0_ff, p1_ff;     // parity of lower / upper index per axis

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
      smp5_ff <= smp4_ff;
      dg5_ff  <= dg4_ff;
      t5_ff   <= t4_ff;
      for (int a = 0; a < 3; a++) begin
         p0_ff[a] <= c04_ff[a][0];
         p1_ff[a] <= c14[a][0];
      end
   end

   // blend along x: four lerps, corners picked by parity
   logic signed [DW-1:0] cx [4];   // index {z,y}
   for (genvar g = 0; g < 4; g++) begin : g_lx
      logic py, pz;
      assign py = g[0] ? p1_ff[1] : p0_ff[1];
      assign pz = g[1] ? p1_ff[2] : p0_ff[2];
      sdfts_lerp #(.DIST_WIDTH(DW)) u_lerp (
         .clock (clock),
         .a     (rd5_ff[{pz, py, p0_ff[0]}]),
         .b     (rd5_ff[{pz, py, p1_ff[0]}]),
         .t     (t5_ff[0]),
         .y     (cx[g])
      );
   end

   logic        v6_ff, smp6_ff, dg6_ff;
   logic [15:0] ty6_ff, tz6_ff;
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else       v6_ff <= v5_ff;
      smp6_ff <= smp5_ff;
      dg6_ff  <= dg5_ff;
      ty6_ff  <= t5_ff[1];
      tz6_ff  <= t5_ff[2];
   end

   // blend along y
   logic signed [DW-1:0] cy [2];
   for (genvar g = 0; g < 2; g++) begin : g_ly
      sdfts_lerp #(.DIST_WIDTH(DW)) u_lerp (
         .clock (clock),
         .a     (cx[2*g]),
         .b     (cx[2*g+1]),
         .t     (ty6_ff),
         .y     (cy[g])
      );
   end

   logic        v7_ff, smp7_ff, dg7_ff;
   logic [15:0] tz7_ff;
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else       v7_ff <= v6_ff;
      smp7_ff <= smp6_ff;
      dg7_ff  <= dg6_ff;
      tz7_ff  <= tz6_ff;
   end

   // blend along z
   logic signed [DW-1:0] cz;
   sdfts_lerp #(.DIST_WIDTH(DW)) u_lerp_z (
      .clock (clock),
      .a     (cy[0]),
      .b     (cy[1]),
      .t     (tz7_ff),
      .y     (cz)
   );

   logic v8_ff, smp8_ff, dg8_ff;
   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else       v8_ff <= v7_ff;
      smp8_ff <= smp7_ff;
      dg8_ff  <= dg7_ff;
   end

   // ---------------------------------------------------------------- result register
   logic               rv_ff, rv_in;
   logic signed [15:0] rd_ff, rd_in;
   logic               rg_ff;
   logic signed [31:0] rw;

   always_comb begin
      rw = 32'(cz);
      if (rw > OUT_MAX)      rw = OUT_MAX;
      else if (rw < OUT_MIN) rw = OUT_MIN;
      rv_in = v8_ff && smp8_ff;
      rd_in = dg8_ff ? '0 : rw[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else       rv_ff <= rv_in;
      rd_ff <= rd_in;
      rg_ff <= dg8_ff;
   end

   assign rsp_valid            = rv_ff;
   assign rsp_sampled_distance = rd_ff;
   assign rsp_degenerate       = rg_ff;

endmodule
